FILE: src/rkc_pkg.sv
// ============================================================================
// RC4 keystream cipher package
// Shared widths, opcodes, controller states and the command and status
// structures that join the controller and the datapath.
// ============================================================================
`default_nettype none

package rkc_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned SBOX_DEPTH = 256;
  localparam int unsigned SBOX_AW    = 8;
  localparam int unsigned KCNT_W     = 9;

  // Values of the opcode field of an input word.
  localparam logic OPC_KEY  = 1'b0;
  localparam logic OPC_DATA = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_KS_RD,
    ST_KS_J,
    ST_KS_WN,
    ST_KS_WJ,
    ST_D_J,
    ST_D_KS,
    ST_D_OUT
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_KEY,
    OP_FILL,
    OP_KS_RD,
    OP_KS_J,
    OP_KS_WN,
    OP_KS_WJ,
    OP_DATA,
    OP_D_J,
    OP_D_KS,
    OP_D_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic n_last;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: src/rkc_if.sv
// ============================================================================
// RC4 keystream cipher channel interfaces
// Valid/ready channels for the input words and the result words.
// ============================================================================
`default_nettype none

interface rkc_in_if;
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic [rkc_pkg::BYTE_W-1:0] byte_value;
  logic                       last;

  modport source (output valid, opcode, byte_value, last, input ready);
  modport sink   (input valid, opcode, byte_value, last, output ready);
endinterface

interface rkc_out_if;
  logic                       valid;
  logic                       ready;
  logic [rkc_pkg::BYTE_W-1:0] out_byte;
  logic                       out_last;

  modport source (output valid, out_byte, out_last, input ready);
  modport sink   (input valid, out_byte, out_last, output ready);
endinterface

`default_nettype wire

FILE: src/rkc_ram.sv
// ============================================================================
// Generic RAM
// One write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module rkc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   wr_en_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]                       wr_data_i,
  input  wire logic                                   rd_en_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]                       rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

FILE: src/rkc_datapath.sv
// ============================================================================
// RC4 keystream cipher datapath
// S-box and key memories, the indices, the schedule counters and the
// result register, stepped by commands from the controller.
// ============================================================================
`default_nettype none

module rkc_datapath #(
  parameter int unsigned KEY_STORE_DEPTH = 256
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire rkc_pkg::dp_cmd_t           cmd_i,
  input  wire logic [rkc_pkg::BYTE_W-1:0] in_byte_i,
  input  wire logic                       in_last_i,
  output rkc_pkg::dp_stat_t               stat_o,
  output logic      [rkc_pkg::BYTE_W-1:0] out_byte_o,
  output logic                            out_last_o
);

  localparam int unsigned KAW = (KEY_STORE_DEPTH > 1) ? $clog2(KEY_STORE_DEPTH) : 1;
  localparam int unsigned BW  = rkc_pkg::BYTE_W;
  localparam int unsigned SAW = rkc_pkg::SBOX_AW;
  localparam int unsigned CW  = rkc_pkg::KCNT_W;

  // Control state.
  logic [SAW-1:0] i_q, i_d;
  logic [SAW-1:0] j_q, j_d;
  logic [SAW-1:0] n_q, n_d;
  logic [KAW-1:0] kidx_q, kidx_d;
  logic [CW-1:0]  key_count_q, key_count_d;

  // Payload registers.
  logic [BW-1:0] sa_q, sa_d;
  logic [BW-1:0] sb_q, sb_d;
  logic [BW-1:0] byte_q, byte_d;
  logic          last_q, last_d;
  logic          hit_i_q, hit_i_d;
  logic          hit_j_q, hit_j_d;
  logic [BW-1:0] out_byte_q, out_byte_d;
  logic          out_last_q, out_last_d;

  // Memory ports.
  logic           sbox_we, sbox_re;
  logic [SAW-1:0] sbox_wa, sbox_ra;
  logic [BW-1:0]  sbox_wd, sbox_rd;
  logic           key_we, key_re;
  logic [KAW-1:0] key_wa, key_ra;
  logic [BW-1:0]  key_rd;

  logic [CW-1:0] key_len;
  logic          key_room;
  logic          kidx_wrap;
  logic [BW-1:0] ks;

  rkc_ram #(
    .WIDTH(BW),
    .DEPTH(rkc_pkg::SBOX_DEPTH)
  ) u_sbox (
    .clk_i    (clk_i),
    .wr_en_i  (sbox_we),
    .wr_addr_i(sbox_wa),
    .wr_data_i(sbox_wd),
    .rd_en_i  (sbox_re),
    .rd_addr_i(sbox_ra),
    .rd_data_o(sbox_rd)
  );

  rkc_ram #(
    .WIDTH(BW),
    .DEPTH(KEY_STORE_DEPTH)
  ) u_key (
    .clk_i    (clk_i),
    .wr_en_i  (key_we),
    .wr_addr_i(key_wa),
    .wr_data_i(in_byte_i),
    .rd_en_i  (key_re),
    .rd_addr_i(key_ra),
    .rd_data_o(key_rd)
  );

  // An empty key behaves as a key of length one.
  assign key_len   = (key_count_q == '0) ? CW'(1) : key_count_q;
  assign key_room  = key_count_q < CW'(KEY_STORE_DEPTH);
  assign kidx_wrap = ({{(CW-KAW){1'b0}}, kidx_q} + CW'(1)) == key_len;

  // The keystream byte: the two swapped entries are written around the read,
  // so a read that hits one of them takes the value from the registers.
  assign ks = hit_j_q ? sa_q : (hit_i_q ? sb_q : sbox_rd);

  assign stat_o.n_last = (n_q == '1);

  always_comb begin
    sbox_we = 1'b0;
    sbox_wa = n_q;
    sbox_wd = n_q;
    sbox_re = 1'b0;
    sbox_ra = n_q;
    key_we  = 1'b0;
    key_wa  = key_count_q[KAW-1:0];
    key_re  = 1'b0;
    key_ra  = kidx_q;

    i_d         = i_q;
    j_d         = j_q;
    n_d         = n_q;
    kidx_d      = kidx_q;
    key_count_d = key_count_q;
    sa_d        = sa_q;
    sb_d        = sb_q;
    byte_d      = byte_q;
    last_d      = last_q;
    hit_i_d     = hit_i_q;
    hit_j_d     = hit_j_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;

    case (cmd_i.op)
      rkc_pkg::OP_KEY: begin
        if (key_room) begin
          key_we      = 1'b1;
          key_count_d = key_count_q + CW'(1);
        end
      end
      rkc_pkg::OP_FILL: begin
        sbox_we = 1'b1;
        n_d     = n_q + SAW'(1);
        i_d     = '0;
        j_d     = '0;
        kidx_d  = '0;
      end
      rkc_pkg::OP_KS_RD: begin
        sbox_re = 1'b1;
        key_re  = 1'b1;
      end
      rkc_pkg::OP_KS_J: begin
        j_d     = j_q + sbox_rd + key_rd;
        sa_d    = sbox_rd;
        sbox_re = 1'b1;
        sbox_ra = j_d;
      end
      rkc_pkg::OP_KS_WN: begin
        sbox_we = 1'b1;
        sbox_wa = n_q;
        sbox_wd = sbox_rd;
      end
      rkc_pkg::OP_KS_WJ: begin
        sbox_we = 1'b1;
        sbox_wa = j_q;
        sbox_wd = sa_q;
        n_d     = n_q + SAW'(1);
        kidx_d  = kidx_wrap ? '0 : kidx_q + KAW'(1);
        if (stat_o.n_last) begin
          i_d         = '0;
          j_d         = '0;
          key_count_d = '0;
        end
      end
      rkc_pkg::OP_DATA: begin
        i_d     = i_q + SAW'(1);
        sbox_re = 1'b1;
        sbox_ra = i_d;
        byte_d  = in_byte_i;
        last_d  = in_last_i;
      end
      rkc_pkg::OP_D_J: begin
        j_d     = j_q + sbox_rd;
        sa_d    = sbox_rd;
        sbox_re = 1'b1;
        sbox_ra = j_d;
      end
      rkc_pkg::OP_D_KS: begin
        sb_d    = sbox_rd;
        sbox_we = 1'b1;
        sbox_wa = i_q;
        sbox_wd = sbox_rd;
        sbox_re = 1'b1;
        sbox_ra = sa_q + sbox_rd;
        hit_i_d = (sbox_ra == i_q);
        hit_j_d = (sbox_ra == j_q);
      end
      rkc_pkg::OP_D_OUT: begin
        sbox_we    = 1'b1;
        sbox_wa    = j_q;
        sbox_wd    = sa_q;
        out_byte_d = byte_q ^ ks;
        out_last_d = last_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q         <= '0;
      j_q         <= '0;
      n_q         <= '0;
      kidx_q      <= '0;
      key_count_q <= '0;
    end else begin
      i_q         <= i_d;
      j_q         <= j_d;
      n_q         <= n_d;
      kidx_q      <= kidx_d;
      key_count_q <= key_count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sa_q       <= sa_d;
    sb_q       <= sb_d;
    byte_q     <= byte_d;
    last_q     <= last_d;
    hit_i_q    <= hit_i_d;
    hit_j_q    <= hit_j_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign out_byte_o = out_byte_q;
  assign out_last_o = out_last_q;

endmodule

`default_nettype wire

FILE: src/rkc_ctrl.sv
// ============================================================================
// RC4 keystream cipher controller
// Sequences the key store, the key schedule and the per-word keystream
// steps, and owns the handshakes of both channels.
// ============================================================================
`default_nettype none

module rkc_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_opcode_i,
  input  wire logic              in_last_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire rkc_pkg::dp_stat_t stat_i,
  output rkc_pkg::dp_cmd_t       cmd_o
);

  rkc_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rkc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o.op    = rkc_pkg::OP_NONE;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;

    case (state_q)
      rkc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_opcode_i == rkc_pkg::OPC_KEY) begin
            cmd_o.op = rkc_pkg::OP_KEY;
            if (in_last_i) begin
              state_d = rkc_pkg::ST_FILL;
            end
          end else begin
            cmd_o.op = rkc_pkg::OP_DATA;
            state_d  = rkc_pkg::ST_D_J;
          end
        end
      end
      rkc_pkg::ST_FILL: begin
        cmd_o.op = rkc_pkg::OP_FILL;
        if (stat_i.n_last) begin
          state_d = rkc_pkg::ST_KS_RD;
        end
      end
      rkc_pkg::ST_KS_RD: begin
        cmd_o.op = rkc_pkg::OP_KS_RD;
        state_d  = rkc_pkg::ST_KS_J;
      end
      rkc_pkg::ST_KS_J: begin
        cmd_o.op = rkc_pkg::OP_KS_J;
        state_d  = rkc_pkg::ST_KS_WN;
      end
      rkc_pkg::ST_KS_WN: begin
        cmd_o.op = rkc_pkg::OP_KS_WN;
        state_d  = rkc_pkg::ST_KS_WJ;
      end
      rkc_pkg::ST_KS_WJ: begin
        cmd_o.op = rkc_pkg::OP_KS_WJ;
        state_d  = stat_i.n_last ? rkc_pkg::ST_IDLE : rkc_pkg::ST_KS_RD;
      end
      rkc_pkg::ST_D_J: begin
        cmd_o.op = rkc_pkg::OP_D_J;
        state_d  = rkc_pkg::ST_D_KS;
      end
      rkc_pkg::ST_D_KS: begin
        cmd_o.op = rkc_pkg::OP_D_KS;
        state_d  = rkc_pkg::ST_D_OUT;
      end
      rkc_pkg::ST_D_OUT: begin
        // The result register must be free before the new word lands in it.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = rkc_pkg::OP_D_OUT;
          out_valid_d = 1'b1;
          state_d     = rkc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rkc_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: src/rc4_keystream_cipher.sv
// ============================================================================
// RC4 keystream cipher
// Loads a key one byte at a word, runs the key schedule and then encrypts or
// decrypts one data byte per word with the RC4 keystream.
// ============================================================================
//
// Key bytes (opcode key) are taken one per cycle and stored; a key byte that
// carries last starts the key schedule, which first writes the identity into
// the S-box and then permutes it in 256 steps; no word is accepted until it
// ends. Key bytes beyond KEY_STORE_DEPTH are dropped, though their last flag
// still starts the schedule. A data byte is accepted only once the one before
// it is through its steps: the cycle that accepts it reads S[i], then come
// the read of S[j], the read of the keystream entry together with the first
// half of the swap, and the second half of the swap together with the load of
// the result register. These steps follow from the three dependent reads of
// the S-box memory, which has one read port and one write port. A finished
// result waits in its own register, so the next word is accepted while the
// result is still being taken; only a data byte that reaches its last step
// while the previous result is still unclaimed waits there. Data sent before
// any key has been scheduled yields undefined bytes.
// ============================================================================
`default_nettype none

module rc4_keystream_cipher #(
  parameter int unsigned KEY_STORE_DEPTH = 256
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rkc_in_if.sink    in_i,
  rkc_out_if.source out_o
);

  rkc_pkg::dp_cmd_t  dp_cmd;
  rkc_pkg::dp_stat_t dp_stat;

  // Controller: handshakes and the sequence of datapath steps.
  rkc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_opcode_i(in_i.opcode),
    .in_last_i  (in_i.last),
    .in_ready_o (in_i.ready),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  // Datapath: memories, indices and the result register.
  rkc_datapath #(
    .KEY_STORE_DEPTH(KEY_STORE_DEPTH)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (dp_cmd),
    .in_byte_i (in_i.byte_value),
    .in_last_i (in_i.last),
    .stat_o    (dp_stat),
    .out_byte_o(out_o.out_byte),
    .out_last_o(out_o.out_last)
  );

endmodule

`default_nettype wire

FILE: tb/rc4_keystream_cipher_test.sv
// ============================================================================
// RC4 keystream cipher testbench
// Feeds key and data words into the cipher, predicts every result word with
// an independent RC4 model of its own and compares the two field by field,
// under several patterns of sender gaps and receiver back-pressure.
// ============================================================================
`default_nettype none

module rc4_keystream_cipher_test;

  // Key store depth given to the block; key bytes past this count are dropped.
  localparam int unsigned KEY_DEPTH = 256;
  // Cycles the receiver refuses results in the back-pressure phase.
  localparam int unsigned HOLD_CYCLES = 400;
  // Settling time at the end: it exceeds a full key schedule, so anything the
  // block still had in flight shows up well within this.
  localparam int unsigned END_SETTLE = 1400;
  // Idle and stall percentages for the four random phases.
  localparam int unsigned SRC_IDLE[4]   = '{0, 54, 0, 13};
  localparam int unsigned SINK_STALL[4] = '{0, 0, 54, 13};
  localparam int unsigned PHASE_WORDS   = 435;

  // One pending input word. When after_drain is set the driver holds the
  // word back until every expected result has come out of the block.
  typedef struct {
    logic                       opcode;
    logic [rkc_pkg::BYTE_W-1:0] byte_value;
    logic                       last;
    logic                       after_drain;
  } in_word_t;

  typedef struct {
    logic [rkc_pkg::BYTE_W-1:0] out_byte;
    logic                       out_last;
  } cipher_word_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Driver side registers; they reach the interface through continuous
  // assignments so that every input of the block is known from time zero.
  logic                       in_valid  = 1'b0;
  logic                       in_opcode = rkc_pkg::OPC_KEY;
  logic [rkc_pkg::BYTE_W-1:0] in_byte   = '0;
  logic                       in_last   = 1'b0;
  logic                       out_ready = 1'b0;

  rkc_in_if  in_ch ();
  rkc_out_if out_ch ();

  assign in_ch.valid      = in_valid;
  assign in_ch.opcode     = in_opcode;
  assign in_ch.byte_value = in_byte;
  assign in_ch.last       = in_last;
  assign out_ch.ready     = out_ready;

  rc4_keystream_cipher #(
    .KEY_STORE_DEPTH(KEY_DEPTH)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  always #2 clk_i = ~clk_i;

  // Words waiting to be offered, and cipher bytes the block still owes us.
  in_word_t     in_words_q[$];
  cipher_word_t cipher_bytes_q[$];

  // Results owed and results received, both registered at the rising edge so
  // the driver and the monitor see each other's counts without a race.
  int unsigned results_due  = 0;
  int unsigned results_seen = 0;

  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  logic        hold_go        = 1'b0;
  int unsigned hold_left      = 0;
  int unsigned err_count      = 0;
  int unsigned words_queued   = 0;
  longint      cycle_count    = 0;
  longint      cycle_limit    = 40000;

  // --------------------------------------------------------------------------
  // Predictor state: the permutation, the key being collected and the two
  // running indices, all at the widths of the block.
  // --------------------------------------------------------------------------
  logic [rkc_pkg::BYTE_W-1:0] ks_sbox   [rkc_pkg::SBOX_DEPTH];
  logic [rkc_pkg::BYTE_W-1:0] key_bytes [KEY_DEPTH];
  logic [rkc_pkg::KCNT_W-1:0] key_fill = '0;
  logic [rkc_pkg::BYTE_W-1:0] ks_i     = '0;
  logic [rkc_pkg::BYTE_W-1:0] ks_j     = '0;

  // Key schedule: identity permutation, then 256 swaps driven by the stored
  // key repeated over its length. The indices and the key count start over.
  function automatic void rekey_sbox();
    int unsigned                span;
    int unsigned                n;
    logic [rkc_pkg::BYTE_W-1:0] jj;
    logic [rkc_pkg::BYTE_W-1:0] t;
    span = (key_fill == 0) ? 1 : key_fill;
    for (n = 0; n < rkc_pkg::SBOX_DEPTH; n++) ks_sbox[n] = 8'(n);
    jj = '0;
    for (n = 0; n < rkc_pkg::SBOX_DEPTH; n++) begin
      jj = jj + ks_sbox[n] + key_bytes[n % span];
      t           = ks_sbox[n];
      ks_sbox[n]  = ks_sbox[jj];
      ks_sbox[jj] = t;
    end
    ks_i     = '0;
    ks_j     = '0;
    key_fill = '0;
  endfunction

  // Applies one accepted word to the predictor. A data word produces one
  // cipher byte; a key word is stored (unless the store is full) and, when
  // flagged last, reschedules the permutation.
  function automatic void absorb_word(logic opc, logic [rkc_pkg::BYTE_W-1:0] b, logic lst);
    logic [rkc_pkg::BYTE_W-1:0] t;
    logic [rkc_pkg::BYTE_W-1:0] sel;
    if (opc == rkc_pkg::OPC_KEY) begin
      if (key_fill < KEY_DEPTH) begin
        key_bytes[key_fill[rkc_pkg::SBOX_AW-1:0]] = b;
        key_fill = key_fill + 1'b1;
      end
      if (lst) rekey_sbox();
    end else begin
      ks_i          = ks_i + 8'd1;
      ks_j          = ks_j + ks_sbox[ks_i];
      t             = ks_sbox[ks_i];
      ks_sbox[ks_i] = ks_sbox[ks_j];
      ks_sbox[ks_j] = t;
      sel           = ks_sbox[ks_i] + ks_sbox[ks_j];
      cipher_bytes_q.push_back('{out_byte: b ^ ks_sbox[sel], out_last: lst});
    end
  endfunction

  function automatic void flag_error(string msg);
    if (err_count < 10) $display("ERROR: %s", msg);
    err_count++;
  endfunction

  // --------------------------------------------------------------------------
  // Driver. A word stays on the bus until it is taken; the next one is put up
  // in the same edge when the queue has one and the sender is not idling.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : drive_p
    in_word_t    nxt;
    logic        took;
    int unsigned due;
    if (!rst_ni) begin
      in_valid    <= 1'b0;
      in_opcode   <= rkc_pkg::OPC_KEY;
      in_byte     <= '0;
      in_last     <= 1'b0;
      results_due <= 0;
    end else begin
      took = in_valid && in_ch.ready;
      due  = results_due;
      if (took) begin
        if (in_opcode == rkc_pkg::OPC_DATA) due = due + 1;
        absorb_word(in_opcode, in_byte, in_last);
      end
      results_due <= due;
      if (took || !in_valid) begin
        if (in_words_q.size() != 0 &&
            !(in_words_q[0].after_drain && due != results_seen) &&
            $urandom_range(99) >= src_idle_pct) begin
          nxt = in_words_q.pop_front();
          in_valid  <= 1'b1;
          in_opcode <= nxt.opcode;
          in_byte   <= nxt.byte_value;
          in_last   <= nxt.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here so it runs independently of the
  // random stalls below.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_go) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. Each taken result word is checked against the oldest expected
  // cipher byte; a word arriving when nothing is owed is an error too.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : watch_p
    cipher_word_t exp_w;
    if (!rst_ni) begin
      out_ready    <= 1'b0;
      results_seen <= 0;
    end else begin
      if (out_ready && out_ch.valid) begin
        if (results_due == results_seen) begin
          flag_error($sformatf("unexpected result word: out_byte %02h out_last %0b",
                               out_ch.out_byte, out_ch.out_last));
        end else begin
          exp_w = cipher_bytes_q.pop_front();
          if (out_ch.out_byte !== exp_w.out_byte)
            flag_error($sformatf("result %0d: out_byte expected %02h, got %02h",
                                 results_seen, exp_w.out_byte, out_ch.out_byte));
          if (out_ch.out_last !== exp_w.out_last)
            flag_error($sformatf("result %0d: out_last expected %0b, got %0b",
                                 results_seen, exp_w.out_last, out_ch.out_last));
          results_seen <= results_seen + 1;
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Watchdog on the whole run; the limit grows with every word queued.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > cycle_limit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus. All queue and knob updates happen on the falling edge, away from
  // the processes that act on the rising edge.
  // --------------------------------------------------------------------------

  // Queues one word and widens the time limit by a generous worst case for
  // it: a last key byte costs a full key schedule, any other word its
  // handshake plus gaps and stalls.
  task automatic push_word(logic opc, logic [rkc_pkg::BYTE_W-1:0] b, logic lst, logic drain);
    in_words_q.push_back('{opcode: opc, byte_value: b, last: lst, after_drain: drain});
    words_queued++;
    cycle_limit += (opc == rkc_pkg::OPC_KEY && lst) ? 4 * 1300 : 4 * 12;
  endtask

  // One random session. Most sessions are a complete key followed by a run
  // of data words, so the keystream gets exercised deeply under many keys.
  // The rest interleave data with a partly loaded key, or are loose data
  // words on the current key. An overlong key covers the dropped key bytes.
  task automatic queue_session(logic long_key);
    int unsigned kind;
    int unsigned klen;
    int unsigned dlen;
    int unsigned n;
    logic        drain;
    kind  = $urandom_range(99);
    drain = ($urandom_range(14) == 0);
    if (long_key || kind < 80) begin
      if (long_key)
        klen = $urandom_range(KEY_DEPTH + 1, KEY_DEPTH + 8);
      else if ($urandom_range(19) == 0)
        klen = $urandom_range(17, 64);
      else
        klen = $urandom_range(1, 16);
      for (n = 0; n < klen; n++)
        push_word(rkc_pkg::OPC_KEY, 8'($urandom_range(255)), n == klen - 1,
                  drain && n == 0);
      dlen = $urandom_range(1, 40);
      for (n = 0; n < dlen; n++)
        push_word(rkc_pkg::OPC_DATA, 8'($urandom_range(255)), n == dlen - 1, 1'b0);
    end else if (kind < 92) begin
      // Data between key bytes still runs on the previous key's permutation.
      klen = $urandom_range(1, 8);
      for (n = 0; n < klen; n++)
        push_word(rkc_pkg::OPC_KEY, 8'($urandom_range(255)), 1'b0, drain && n == 0);
      dlen = $urandom_range(1, 10);
      for (n = 0; n < dlen; n++)
        push_word(rkc_pkg::OPC_DATA, 8'($urandom_range(255)), 1'($urandom_range(1)),
                  1'b0);
      push_word(rkc_pkg::OPC_KEY, 8'($urandom_range(255)), 1'b1, 1'b0);
    end else begin
      dlen = $urandom_range(1, 10);
      for (n = 0; n < dlen; n++)
        push_word(rkc_pkg::OPC_DATA, 8'($urandom_range(255)), 1'($urandom_range(1)),
                  drain && n == 0);
    end
  endtask

  // Waits until every queued word is taken and every result has arrived.
  task automatic wait_quiet();
    while (in_words_q.size() != 0 || in_valid || results_due != results_seen)
      @(negedge clk_i);
  endtask

  initial begin : stimulus_p
    int unsigned n;
    int unsigned p;
    int unsigned goal;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part. A one-byte all-zero key, data at both byte extremes and
    // a last data byte followed by more data (the keystream must continue).
    push_word(rkc_pkg::OPC_KEY,  8'h00, 1'b1, 1'b0);
    push_word(rkc_pkg::OPC_DATA, 8'h00, 1'b0, 1'b0);
    push_word(rkc_pkg::OPC_DATA, 8'hFF, 1'b0, 1'b0);
    push_word(rkc_pkg::OPC_DATA, 8'hA5, 1'b1, 1'b0);
    push_word(rkc_pkg::OPC_DATA, 8'h5A, 1'b0, 1'b0);
    // A new key, loaded only after everything so far has drained, with data
    // slipped in between its bytes.
    push_word(rkc_pkg::OPC_KEY,  8'hFF, 1'b0, 1'b1);
    push_word(rkc_pkg::OPC_KEY,  8'h80, 1'b0, 1'b0);
    push_word(rkc_pkg::OPC_KEY,  8'h01, 1'b0, 1'b0);
    push_word(rkc_pkg::OPC_DATA, 8'h3C, 1'b1, 1'b0);
    push_word(rkc_pkg::OPC_DATA, 8'hC3, 1'b0, 1'b0);
    push_word(rkc_pkg::OPC_KEY,  8'h7F, 1'b1, 1'b0);
    push_word(rkc_pkg::OPC_DATA, 8'hFF, 1'b1, 1'b0);
    push_word(rkc_pkg::OPC_DATA, 8'h00, 1'b0, 1'b0);
    push_word(rkc_pkg::OPC_DATA, 8'h81, 1'b0, 1'b0);
    // A one-byte all-ones key.
    push_word(rkc_pkg::OPC_KEY,  8'hFF, 1'b1, 1'b0);
    push_word(rkc_pkg::OPC_DATA, 8'h12, 1'b0, 1'b0);
    push_word(rkc_pkg::OPC_DATA, 8'hFE, 1'b1, 1'b0);
    wait_quiet();

    // Back-pressure: the receiver refuses results for a long stretch while
    // the sender keeps offering data, so the block's result register fills
    // and it has to stall its input.
    for (n = 0; n < 48; n++)
      push_word(rkc_pkg::OPC_DATA, 8'($urandom_range(255)), n == 47, n == 0);
    hold_go = 1'b1;
    @(negedge clk_i);
    hold_go = 1'b0;
    wait_quiet();

    // Random phases under different gap and stall patterns.
    for (p = 0; p < 4; p++) begin
      src_idle_pct   = SRC_IDLE[p];
      sink_stall_pct = SINK_STALL[p];
      goal = words_queued + PHASE_WORDS;
      queue_session(p == 0 || p == 2);
      while (words_queued < goal) queue_session(1'b0);
      wait_quiet();
    end

    repeat (END_SETTLE) @(negedge clk_i);
    if (err_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire

FILE: rc4_keystream_cipher.f
src/rkc_pkg.sv
src/rkc_if.sv
src/rkc_ram.sv
src/rkc_datapath.sv
src/rkc_ctrl.sv
src/rc4_keystream_cipher.sv
tb/rc4_keystream_cipher_test.sv
